// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/crtm_pkg.sv =====
// ----------------------------------------------------------------------------
// crtm_pkg
// Shared types and codes of the card range table match block.
// ----------------------------------------------------------------------------
package crtm_pkg;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_MATCH = 2'd1;
	localparam logic [1:0] MODE_CHECK = 2'd2;

	localparam logic [3:0] NIB_END = 4'hF;
	localparam logic [4:0] MAX_DIGITS = 5'd20;

	typedef struct packed {
		logic [1:0]  mode;
		logic [3:0]  entry_index;
		logic [39:0] pan_lead;
		logic [39:0] pan_trail;
		logic [39:0] range_low;
		logic [39:0] range_high;
		logic [7:0]  length_bcd;
		logic [7:0]  range_id;
	} req_t;

	typedef struct packed {
		logic       found;
		logic [3:0] match_index;
		logic [7:0] match_id;
		logic [4:0] pan_length;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic rd_scan;
		logic rd_id;
		logic take;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic id_ok;
	} status_t;

endpackage

// ===== rtl/crtm_ctrl.sv =====
// ----------------------------------------------------------------------------
// crtm_ctrl
// Sequencer: accepts commands, steps the table scan, raises the result strobe.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crtm_ctrl #(
	parameter int TABLE_ENTRIES = 16,
	parameter int IW = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         mode,
	input  crtm_pkg::status_t  status,
	output crtm_pkg::cmd_t     cmd,
	output logic [IW-1:0]      scan_addr,
	output logic               busy,
	output logic               done
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ID_RD,
		ST_ID_TAKE
	} state_t;

	state_t        state_q;
	logic [IW-1:0] scan_q;
	logic          pend_q;
	logic          last_q;
	logic          done_q;
	logic          scan_stop;

	// data of the previous read sits in the datapath read register
	assign scan_stop = pend_q && (status.hit || last_q);

	always_comb begin
		cmd.load    = start && (state_q == ST_IDLE);
		cmd.rd_scan = (state_q == ST_SCAN) && !scan_stop;
		cmd.rd_id   = (state_q == ST_ID_RD) && status.id_ok;
		cmd.take    = ((state_q == ST_SCAN) && pend_q && status.hit) ||
		              (state_q == ST_ID_TAKE);
	end

	assign scan_addr = scan_q;
	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scan_q  <= '0;
			pend_q  <= 1'b0;
			last_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						scan_q <= '0;
						pend_q <= 1'b0;
						last_q <= 1'b0;
						unique case (mode)
							crtm_pkg::MODE_MATCH: state_q <= ST_SCAN;
							crtm_pkg::MODE_CHECK: state_q <= ST_ID_RD;
							default:              done_q  <= 1'b1;
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_stop) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						pend_q <= 1'b1;
						last_q <= (scan_q == IW'(TABLE_ENTRIES - 1));
						scan_q <= scan_q + IW'(1);
					end
				end
				ST_ID_RD: begin
					if (status.id_ok) begin
						state_q <= ST_ID_TAKE;
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_ID_TAKE: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_PROP(a_done_idle, done_q |-> !busy, "result strobe while busy")
	`ASSERT_PROP(a_accept_moves, (start && !busy) |=> (busy || done_q), "accepted transfer dropped")
	`ASSERT_NEVER(a_take_no_data, (state_q == ST_SCAN) && cmd.take && !pend_q, "take without read data")

endmodule

// ===== rtl/crtm_dp.sv =====
// ----------------------------------------------------------------------------
// crtm_dp
// Datapath: range table memory, digit count, prefix and length compare,
// BCD id decode and result register.
// ----------------------------------------------------------------------------
module crtm_dp #(
	parameter int TABLE_ENTRIES = 16,
	parameter int PREFIX_BYTES = 5,
	parameter int IW = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  crtm_pkg::req_t     req,
	input  crtm_pkg::cmd_t     cmd,
	input  logic [IW-1:0]      scan_addr,
	output crtm_pkg::status_t  status,
	output crtm_pkg::rsp_t     rsp
);

	localparam int PW = PREFIX_BYTES * 8;

	typedef struct packed {
		logic [39:0] low;
		logic [39:0] high;
		logic [7:0]  len;
		logic [7:0]  id;
	} entry_t;

	function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
		return 8'({4'd0, b[7:4]} * 8'd10) + {4'd0, b[3:0]};
	endfunction

	// nibble count up to the first end nibble
	function automatic logic [4:0] digit_count(input logic [79:0] card);
		logic [4:0] cnt;
		cnt = crtm_pkg::MAX_DIGITS;
		for (int j = 19; j >= 0; j--) begin
			if (card[79 - 4 * j -: 4] == crtm_pkg::NIB_END) begin
				cnt = 5'(j);
			end
		end
		return cnt;
	endfunction

	entry_t             mem_q [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;
	entry_t             rd_s1;
	logic               rd_vld_s1;
	logic [IW-1:0]      rd_addr_s1;
	logic [PW-1:0]      pref_q;
	logic [4:0]         plen_q;
	logic               id_ok_q;
	logic [IW-1:0]      id_addr_q;
	crtm_pkg::rsp_t     rsp_q;

	logic [79:0]        card;
	logic [4:0]         count;
	logic [7:0]         id_bin;
	logic               id_ok;
	logic               wr_en;
	logic [IW-1:0]      wr_addr;
	logic               rd_en;
	logic [IW-1:0]      rd_addr;
	entry_t             ent;
	logic               len_ok;
	logic               range_ok;

	assign card    = {req.pan_lead, req.pan_trail};
	assign count   = digit_count(card);
	assign id_bin  = bcd_to_bin(req.range_id);
	assign id_ok   = (id_bin != 8'd0) && (32'(id_bin) <= TABLE_ENTRIES);

	assign wr_en   = cmd.load && (req.mode == crtm_pkg::MODE_WRITE) &&
	                 (32'(req.entry_index) < TABLE_ENTRIES);
	assign wr_addr = IW'(req.entry_index);
	assign rd_en   = cmd.rd_scan || cmd.rd_id;
	assign rd_addr = cmd.rd_id ? id_addr_q : scan_addr;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= '{low: req.range_low, high: req.range_high,
			                    len: req.length_bcd, id: req.range_id};
		end
		if (rd_en) begin
			rd_s1      <= mem_q[rd_addr];
			rd_addr_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_s1 <= valid_q[rd_addr];
			end
		end
	end

	// never-written entries read as zero
	assign ent      = rd_vld_s1 ? rd_s1 : '0;
	assign len_ok   = (ent.len == 8'd0) || (bcd_to_bin(ent.len) == {3'd0, plen_q});
	assign range_ok = (pref_q >= PW'(ent.low)) && (pref_q <= PW'(ent.high));

	assign status.hit   = len_ok && range_ok;
	assign status.id_ok = id_ok_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pref_q    <= card[79 -: PW];
			plen_q    <= count;
			id_ok_q   <= id_ok;
			id_addr_q <= IW'(id_bin - 8'd1);
			rsp_q     <= '{found: 1'b0, match_index: 4'd0, match_id: 8'd0,
			               pan_length: (req.mode == crtm_pkg::MODE_MATCH) ? count : 5'd0};
		end else if (cmd.take) begin
			rsp_q.found       <= 1'b1;
			rsp_q.match_index <= 4'(rd_addr_s1);
			rsp_q.match_id    <= ent.id;
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== rtl/card_range_table_match.sv =====
// ----------------------------------------------------------------------------
// card_range_table_match
// Card range table: entry write, BCD card number range match, BCD id check.
// ----------------------------------------------------------------------------
// A command transfer is taken when start is high and busy is low; its result
// shows on rsp for exactly one cycle with done high, and must be taken then.
// A table write or an unused mode gives its result in the cycle after the
// transfer; an id check reads the entry its id names (none if out of range).
// A card match reads the table through its single read port one entry per
// cycle and stops at the first entry that hits (the lowest index), or after
// the last entry when none hits. busy drops in the cycle the result is
// shown, so the next command may be taken then.
// ----------------------------------------------------------------------------
module card_range_table_match #(
	parameter int TABLE_ENTRIES = 16,
	parameter int PREFIX_BYTES = 5
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  crtm_pkg::req_t  req,
	output logic            done,
	output crtm_pkg::rsp_t  rsp
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	crtm_pkg::cmd_t    cmd;
	crtm_pkg::status_t status;
	logic [IW-1:0]     scan_addr;

	crtm_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.IW(IW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.mode(req.mode),
		.status(status),
		.cmd(cmd),
		.scan_addr(scan_addr),
		.busy(busy),
		.done(done)
	);

	crtm_dp #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.PREFIX_BYTES(PREFIX_BYTES),
		.IW(IW)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.cmd(cmd),
		.scan_addr(scan_addr),
		.status(status),
		.rsp(rsp)
	);

endmodule
